### rtl/assert_macros.svh
// Assertion macros for the grid bucketing RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define GBK_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define GBK_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/gbk_pkg.sv
// Shared types, constants and helpers of the grid bucketing keypoint core.
package gbk_pkg;

    localparam int CFG_W      = 12;  // widest configuration register
    localparam int CFG_ADDR_W = 2;   // configuration register index
    localparam int DIM_W      = 4;   // grid_cols / grid_rows registers
    localparam int GRID_W     = 3;   // one column or row number (0..7)
    localparam int CNT_W      = 7;   // cell counts up to 64 inclusive
    localparam int CELL_IDX_W = 6;   // cell_index result field

    localparam logic [DIM_W-1:0] GRID_MAX = DIM_W'(8);

    // Configuration register indexes
    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_CELL_WIDTH  = 2'd0,
        REG_CELL_HEIGHT = 2'd1,
        REG_GRID_COLS   = 2'd2,
        REG_GRID_ROWS   = 2'd3
    } cfg_reg_t;

    // Input command codes
    localparam logic CMD_KEYPOINT = 1'b0;
    localparam logic CMD_FLUSH    = 1'b1;

    // Bucket found by the divider
    typedef struct packed {
        logic [GRID_W-1:0] col;
        logic [GRID_W-1:0] row;
    } div_res_t;

    // Commands to the cell store
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clr_all;
    } store_ctl_t;

    // Clamp a grid dimension to 1..GRID_MAX
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > GRID_MAX) begin
            r = GRID_MAX;
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

### rtl/gbk_div_unit.sv
// Shared subtract-compare unit that finds the column, then the row, of a keypoint.
module gbk_div_unit #(
    parameter int COORD_BITS = 12
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [COORD_BITS-1:0]       pos_x,    // sampled on start
    input  logic [COORD_BITS-1:0]       pos_y,    // sampled when the column is done
    input  logic [gbk_pkg::CFG_W-1:0]   cell_w,
    input  logic [gbk_pkg::CFG_W-1:0]   cell_h,
    input  logic [gbk_pkg::DIM_W-1:0]   cols,     // already clamped to 1..8
    input  logic [gbk_pkg::DIM_W-1:0]   rows,     // already clamped to 1..8
    output logic                        done,
    output gbk_pkg::div_res_t           res
);
    import gbk_pkg::*;

    localparam int DW = (COORD_BITS > CFG_W) ? COORD_BITS : CFG_W;

    typedef enum logic [1:0] {D_IDLE, D_X, D_Y} dstate_t;

    dstate_t           state_reg, state_next;
    logic [DW-1:0]     rem_reg, rem_next;
    logic [GRID_W-1:0] q_reg, q_next;
    div_res_t          res_reg, res_next;
    logic              done_reg, done_next;

    logic [DW-1:0]     size_cur;
    logic [GRID_W-1:0] lim_cur;
    logic [DW-1:0]     diff;
    logic              fits;

    // Shared unit: one subtract and compare per cycle, quotient saturates at the limit
    assign size_cur = (state_reg == D_Y) ? DW'(cell_h) : DW'(cell_w);
    assign lim_cur  = (state_reg == D_Y) ? GRID_W'(rows - DIM_W'(1))
                                         : GRID_W'(cols - DIM_W'(1));
    assign diff     = rem_reg - size_cur;
    assign fits     = (q_reg != lim_cur) && (rem_reg >= size_cur);

    // Sequence: column phase, then row phase
    always_comb begin
        state_next = state_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        res_next   = res_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            D_IDLE: begin
                if (start) begin
                    rem_next   = DW'(pos_x);
                    q_next     = '0;
                    state_next = D_X;
                end
            end
            D_X: begin
                if (fits) begin
                    rem_next = diff;
                    q_next   = q_reg + GRID_W'(1);
                end else begin
                    res_next.col = q_reg;
                    rem_next     = DW'(pos_y);
                    q_next       = '0;
                    state_next   = D_Y;
                end
            end
            D_Y: begin
                if (fits) begin
                    rem_next = diff;
                    q_next   = q_reg + GRID_W'(1);
                end else begin
                    res_next.row = q_reg;
                    done_next    = 1'b1;
                    state_next   = D_IDLE;
                end
            end
            default: begin
                state_next = D_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        q_reg   <= q_next;
        res_reg <= res_next;
        if (!aresetn) begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

### rtl/gbk_cell_store.sv
// Per-cell winner memory with registered read and resettable valid bits.
module gbk_cell_store #(
    parameter int DEPTH      = 64,
    parameter int AW         = 6,
    parameter int COORD_BITS = 12,
    parameter int RESP_BITS  = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  gbk_pkg::store_ctl_t   ctl,
    input  logic [AW-1:0]         addr,
    input  logic [COORD_BITS-1:0] wr_x,
    input  logic [COORD_BITS-1:0] wr_y,
    input  logic [RESP_BITS-1:0]  wr_resp,
    output logic [COORD_BITS-1:0] rd_x,
    output logic [COORD_BITS-1:0] rd_y,
    output logic [RESP_BITS-1:0]  rd_resp,
    output logic                  vld
);
    import gbk_pkg::*;

    logic [COORD_BITS-1:0] mem_x    [DEPTH];
    logic [COORD_BITS-1:0] mem_y    [DEPTH];
    logic [RESP_BITS-1:0]  mem_resp [DEPTH];

    logic [COORD_BITS-1:0] rd_x_reg;
    logic [COORD_BITS-1:0] rd_y_reg;
    logic [RESP_BITS-1:0]  rd_resp_reg;
    logic [DEPTH-1:0]      valid_reg;

    // Write and registered read, one address
    always_ff @(posedge aclk) begin
        if (ctl.wr_en) begin
            mem_x[addr]    <= wr_x;
            mem_y[addr]    <= wr_y;
            mem_resp[addr] <= wr_resp;
        end
        if (ctl.rd_en) begin
            rd_x_reg    <= mem_x[addr];
            rd_y_reg    <= mem_y[addr];
            rd_resp_reg <= mem_resp[addr];
        end
    end

    // Set on write, drop all on clear
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (ctl.clr_all) begin
            valid_reg <= '0;
        end else if (ctl.wr_en) begin
            valid_reg[addr] <= 1'b1;
        end
    end

    assign rd_x    = rd_x_reg;
    assign rd_y    = rd_y_reg;
    assign rd_resp = rd_resp_reg;
    assign vld     = valid_reg[addr];

endmodule

### rtl/grid_bucket_best_keypoint_core.sv
// Top level of the grid bucketing keypoint selector: sequencer, config and output register.
//
// Use: keypoint and flush beats enter on the s_ channel; s_tuser is the command
// (0 = keypoint, 1 = flush). A keypoint beat produces no output: its cell is found
// by a shared subtract-compare unit that steps the quotient once per cycle, and
// then ST_IDX, ST_RD and ST_UPD read and update the cell before s_tready returns.
// A flush beat walks the cells of the grid in row-major order, skipping empty
// cells in ST_SCAN and reading occupied ones in ST_FRD, and sends one m_ beat per
// occupied cell, the final one with m_tlast; with no cell occupied it sends a
// single beat with m_tuser (empty) and m_tlast set. The flush then clears all cells.
// The output register lets the next command enter while the last result waits.
// When the receiver stalls, the walk holds with one winner pending and resumes
// when m_tready returns. Reset returns the config registers to 64 x 64 pixel
// cells on an 8 x 8 grid, clears all cells and drops m_tvalid. Config writes
// (cfg_we, cfg_addr, cfg_wdata) take effect at once and belong in idle time.
`include "assert_macros.svh"

module grid_bucket_best_keypoint_core #(
    parameter  int MAX_CELLS  = 64,
    parameter  int COORD_BITS = 12,
    parameter  int RESP_BITS  = 16,
    localparam int S_DW = ((2 * COORD_BITS + RESP_BITS + 7) / 8) * 8,
    localparam int M_DW = ((gbk_pkg::CELL_IDX_W + 2 * COORD_BITS + RESP_BITS + 7) / 8) * 8
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration write port
    input  logic                           cfg_we,
    input  logic [gbk_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [gbk_pkg::CFG_W-1:0]      cfg_wdata,
    // command channel
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [S_DW-1:0]                s_tdata,   // x, y, response
    input  logic                           s_tuser,   // cmd
    // result channel
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [M_DW-1:0]                m_tdata,   // cell_index, win_x, win_y, win_response
    output logic                           m_tuser,   // empty_res
    output logic                           m_tlast    // last
);
    import gbk_pkg::*;

    localparam int AW = (MAX_CELLS > 1) ? $clog2(MAX_CELLS) : 1;
    localparam logic [CNT_W-1:0] MAX_N = CNT_W'(MAX_CELLS);

    typedef enum logic [2:0] {
        ST_IDLE, ST_DIV, ST_IDX, ST_RD, ST_UPD, ST_SCAN, ST_FRD, ST_FEND
    } state_t;

    // Configuration registers
    logic [CFG_W-1:0] cell_w_reg, cell_h_reg;
    logic [DIM_W-1:0] grid_cols_reg, grid_rows_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cell_w_reg    <= CFG_W'(64);
            cell_h_reg    <= CFG_W'(64);
            grid_cols_reg <= DIM_W'(8);
            grid_rows_reg <= DIM_W'(8);
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_CELL_WIDTH:  cell_w_reg    <= cfg_wdata;
                REG_CELL_HEIGHT: cell_h_reg    <= cfg_wdata;
                REG_GRID_COLS:   grid_cols_reg <= cfg_wdata[DIM_W-1:0];
                REG_GRID_ROWS:   grid_rows_reg <= cfg_wdata[DIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Grid geometry
    logic [DIM_W-1:0] cols_c, rows_c;
    logic [CNT_W-1:0] grid_n, ncells;

    assign cols_c = clamp_dim(grid_cols_reg);
    assign rows_c = clamp_dim(grid_rows_reg);
    assign grid_n = CNT_W'(cols_c) * CNT_W'(rows_c);
    assign ncells = (grid_n > MAX_N) ? MAX_N : grid_n;

    // Input beat fields
    logic [COORD_BITS-1:0] s_x, s_y;
    logic [RESP_BITS-1:0]  s_resp;

    assign s_x    = s_tdata[COORD_BITS-1:0];
    assign s_y    = s_tdata[2*COORD_BITS-1:COORD_BITS];
    assign s_resp = s_tdata[2*COORD_BITS+RESP_BITS-1:2*COORD_BITS];

    // Sequencer registers
    state_t                state_reg, state_next;
    logic [COORD_BITS-1:0] kp_x_reg, kp_x_next, kp_y_reg, kp_y_next;
    logic [RESP_BITS-1:0]  kp_resp_reg, kp_resp_next;
    logic [AW-1:0]         idx_reg, idx_next;
    logic [CNT_W-1:0]      scan_reg, scan_next;
    logic                  pend_valid_reg, pend_valid_next;
    logic [CELL_IDX_W-1:0] pend_idx_reg, pend_idx_next;
    logic [COORD_BITS-1:0] pend_x_reg, pend_x_next, pend_y_reg, pend_y_next;
    logic [RESP_BITS-1:0]  pend_resp_reg, pend_resp_next;
    logic                  out_valid_reg, out_valid_next;
    logic [CELL_IDX_W-1:0] out_idx_reg, out_idx_next;
    logic [COORD_BITS-1:0] out_x_reg, out_x_next, out_y_reg, out_y_next;
    logic [RESP_BITS-1:0]  out_resp_reg, out_resp_next;
    logic                  out_empty_reg, out_empty_next;
    logic                  out_last_reg, out_last_next;

    // Divider and store hookup
    logic                  div_start, div_done;
    div_res_t              div_res;
    store_ctl_t            st_ctl;
    logic [AW-1:0]         st_addr;
    logic [COORD_BITS-1:0] st_rd_x, st_rd_y;
    logic [RESP_BITS-1:0]  st_rd_resp;
    logic                  st_vld;

    gbk_div_unit #(
        .COORD_BITS (COORD_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .pos_x   (s_x),
        .pos_y   (kp_y_reg),
        .cell_w  (cell_w_reg),
        .cell_h  (cell_h_reg),
        .cols    (cols_c),
        .rows    (rows_c),
        .done    (div_done),
        .res     (div_res)
    );

    gbk_cell_store #(
        .DEPTH      (MAX_CELLS),
        .AW         (AW),
        .COORD_BITS (COORD_BITS),
        .RESP_BITS  (RESP_BITS)
    ) u_store (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (st_ctl),
        .addr    (st_addr),
        .wr_x    (kp_x_reg),
        .wr_y    (kp_y_reg),
        .wr_resp (kp_resp_reg),
        .rd_x    (st_rd_x),
        .rd_y    (st_rd_y),
        .rd_resp (st_rd_resp),
        .vld     (st_vld)
    );

    // Row-major index, clamped to the last existing cell
    logic [CNT_W-1:0] idx_raw, idx_clamped;

    assign idx_raw     = CNT_W'(div_res.row) * CNT_W'(cols_c) + CNT_W'(div_res.col);
    assign idx_clamped = (idx_raw >= ncells) ? (ncells - CNT_W'(1)) : idx_raw;

    // The walk addresses the store only while scanning
    assign st_addr = (state_reg == ST_SCAN) ? scan_reg[AW-1:0] : idx_reg;

    logic out_free;
    assign out_free = !out_valid_reg || m_tready;

    // Next-state and datapath control
    always_comb begin
        state_next      = state_reg;
        kp_x_next       = kp_x_reg;
        kp_y_next       = kp_y_reg;
        kp_resp_next    = kp_resp_reg;
        idx_next        = idx_reg;
        scan_next       = scan_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        pend_x_next     = pend_x_reg;
        pend_y_next     = pend_y_reg;
        pend_resp_next  = pend_resp_reg;
        out_valid_next  = out_valid_reg;
        out_idx_next    = out_idx_reg;
        out_x_next      = out_x_reg;
        out_y_next      = out_y_reg;
        out_resp_next   = out_resp_reg;
        out_empty_next  = out_empty_reg;
        out_last_next   = out_last_reg;
        st_ctl          = '0;
        div_start       = 1'b0;

        // drop the result once taken
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    kp_x_next    = s_x;
                    kp_y_next    = s_y;
                    kp_resp_next = s_resp;
                    if (s_tuser == CMD_FLUSH) begin
                        scan_next       = '0;
                        pend_valid_next = 1'b0;
                        state_next      = ST_SCAN;
                    end else begin
                        div_start  = 1'b1;
                        state_next = ST_DIV;
                    end
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_IDX;
                end
            end
            ST_IDX: begin
                idx_next   = idx_clamped[AW-1:0];
                state_next = ST_RD;
            end
            ST_RD: begin
                st_ctl.rd_en = 1'b1;
                state_next   = ST_UPD;
            end
            ST_UPD: begin
                // earlier keypoint wins a tie
                if (!st_vld || (kp_resp_reg > st_rd_resp)) begin
                    st_ctl.wr_en = 1'b1;
                end
                state_next = ST_IDLE;
            end
            ST_SCAN: begin
                priority if (scan_reg == ncells) begin
                    state_next = ST_FEND;
                end else if (st_vld) begin
                    st_ctl.rd_en = 1'b1;
                    state_next   = ST_FRD;
                end else begin
                    scan_next = scan_reg + CNT_W'(1);
                end
            end
            ST_FRD: begin
                // advance only when the pending winner can move to the output
                if (!pend_valid_reg || out_free) begin
                    if (pend_valid_reg) begin
                        out_valid_next = 1'b1;
                        out_idx_next   = pend_idx_reg;
                        out_x_next     = pend_x_reg;
                        out_y_next     = pend_y_reg;
                        out_resp_next  = pend_resp_reg;
                        out_empty_next = 1'b0;
                        out_last_next  = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_idx_next   = scan_reg[CELL_IDX_W-1:0];
                    pend_x_next     = st_rd_x;
                    pend_y_next     = st_rd_y;
                    pend_resp_next  = st_rd_resp;
                    scan_next       = scan_reg + CNT_W'(1);
                    state_next      = ST_SCAN;
                end
            end
            ST_FEND: begin
                // send the final winner, or the empty marker, then clear all cells
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_last_next  = 1'b1;
                    if (pend_valid_reg) begin
                        out_idx_next   = pend_idx_reg;
                        out_x_next     = pend_x_reg;
                        out_y_next     = pend_y_reg;
                        out_resp_next  = pend_resp_reg;
                        out_empty_next = 1'b0;
                    end else begin
                        out_idx_next   = '0;
                        out_x_next     = '0;
                        out_y_next     = '0;
                        out_resp_next  = '0;
                        out_empty_next = 1'b1;
                    end
                    pend_valid_next = 1'b0;
                    st_ctl.clr_all  = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge aclk) begin
        kp_x_reg      <= kp_x_next;
        kp_y_reg      <= kp_y_next;
        kp_resp_reg   <= kp_resp_next;
        idx_reg       <= idx_next;
        scan_reg      <= scan_next;
        pend_idx_reg  <= pend_idx_next;
        pend_x_reg    <= pend_x_next;
        pend_y_reg    <= pend_y_next;
        pend_resp_reg <= pend_resp_next;
        out_idx_reg   <= out_idx_next;
        out_x_reg     <= out_x_next;
        out_y_reg     <= out_y_next;
        out_resp_reg  <= out_resp_next;
        out_empty_reg <= out_empty_next;
        out_last_reg  <= out_last_next;
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Ports
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = M_DW'({out_resp_reg, out_y_reg, out_x_reg, out_idx_reg});
    assign m_tuser  = out_empty_reg;
    assign m_tlast  = out_last_reg;

    // Checks
    `GBK_ASSERT_NEXT(a_busy_after_beat, s_tvalid && s_tready, !s_tready, "accepted beat did not stall input")
    `GBK_ASSERT_IMPL(a_empty_is_last, m_tvalid && m_tuser, m_tlast, "empty result without last")
    `GBK_ASSERT_IMPL(a_idx_in_grid, state_reg == ST_RD, CNT_W'(idx_reg) < ncells, "cell index beyond grid")

endmodule

### bench/tb_grid_bucket_best_keypoint_core.sv
// Self-checking testbench of the grid bucketing keypoint selector core.
module tb_grid_bucket_best_keypoint_core;
    import gbk_pkg::*;

    localparam int CELLS         = 64;
    localparam int S_W           = 40;      // {response, y, x}
    localparam int M_W           = 48;      // {pad, win_response, win_y, win_x, cell_index}
    localparam int MAX_GAP       = 18;
    localparam int SETTLE_CYCLES = 120;     // longest keypoint divide plus a full cell walk
    localparam int CYCLE_LIMIT   = 600000;
    localparam int MAX_REPORTS   = 40;
    localparam int RANDOM_ITEMS  = 100;

    // One winner beat as seen on the result channel
    typedef struct packed {
        logic [5:0]  idx;
        logic [11:0] wx;
        logic [11:0] wy;
        logic [15:0] wresp;
        logic        empty_flag;
        logic        last_flag;
    } cell_winner_t;

    logic           aclk      = 1'b0;
    logic           aresetn   = 1'b0;
    logic           cfg_we    = 1'b0;
    cfg_reg_t       cfg_addr  = REG_CELL_WIDTH;
    logic [11:0]    cfg_wdata = '0;
    logic           s_tvalid  = 1'b0;
    logic           s_tready;
    logic [S_W-1:0] s_tdata   = '0;
    logic           s_tuser   = 1'b0;
    logic           m_tvalid;
    logic           m_tready  = 1'b0;
    logic [M_W-1:0] m_tdata;
    logic           m_tuser;
    logic           m_tlast;

    // Predicted grid state
    logic [11:0]      cell_w_q    = 12'd64;
    logic [11:0]      cell_h_q    = 12'd64;
    logic [3:0]       grid_cols_q = 4'd8;
    logic [3:0]       grid_rows_q = 4'd8;
    logic [11:0]      keep_x    [CELLS];
    logic [11:0]      keep_y    [CELLS];
    logic [15:0]      keep_resp [CELLS];
    logic [CELLS-1:0] keep_valid  = '0;

    cell_winner_t pending_winners[$];

    int  cycle_count    = 0;
    int  mismatch_count = 0;
    int  winners_seen   = 0;
    int  keypoints_sent = 0;
    int  flushes_sent   = 0;
    int  grid_settings  = 0;
    int  rx_hold_len    = 0;
    bit  tx_no_idle     = 1'b0;
    bit  rx_no_idle     = 1'b0;

    grid_bucket_best_keypoint_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    always #1 aclk = ~aclk;

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d winners still pending",
                     cycle_count, pending_winners.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("MISMATCH cycle %0d: %s", cycle_count, msg);
        end
    endtask

    // Keep the strongest keypoint per cell; on flush queue every occupied cell of the grid in order
    task automatic track_best_per_cell(input logic cmd, input logic [11:0] px,
                                       input logic [11:0] py, input logic [15:0] pr);
        int cols, rows, ncells, col, row, idx, n, i;
        cell_winner_t w;
        cols = (grid_cols_q == 4'd0) ? 1 : (grid_cols_q > 4'd8) ? 8 : int'(grid_cols_q);
        rows = (grid_rows_q == 4'd0) ? 1 : (grid_rows_q > 4'd8) ? 8 : int'(grid_rows_q);
        ncells = (cols * rows > CELLS) ? CELLS : cols * rows;
        if (cmd == CMD_KEYPOINT) begin
            // zero cell size saturates the quotient into the last column or row
            col = (cell_w_q == 12'd0) ? cols : int'(px) / int'(cell_w_q);
            row = (cell_h_q == 12'd0) ? rows : int'(py) / int'(cell_h_q);
            if (col >= cols) col = cols - 1;
            if (row >= rows) row = rows - 1;
            idx = row * cols + col;
            if (idx >= ncells) idx = ncells - 1;
            // ties keep the earlier keypoint
            if (!keep_valid[idx] || pr > keep_resp[idx]) begin
                keep_valid[idx] = 1'b1;
                keep_x[idx]     = px;
                keep_y[idx]     = py;
                keep_resp[idx]  = pr;
            end
        end else begin
            n = 0;
            for (i = 0; i < ncells; i++) begin
                if (keep_valid[i]) begin
                    w.idx        = 6'(i);
                    w.wx         = keep_x[i];
                    w.wy         = keep_y[i];
                    w.wresp      = keep_resp[i];
                    w.empty_flag = 1'b0;
                    w.last_flag  = 1'b0;
                    pending_winners.insert(pending_winners.size(), w);
                    n++;
                end
            end
            if (n == 0) begin
                w = '0;
                w.empty_flag = 1'b1;
                w.last_flag  = 1'b1;
                pending_winners.insert(pending_winners.size(), w);
            end else begin
                pending_winners[pending_winners.size() - 1].last_flag = 1'b1;
            end
            // flush clears every cell, also the ones beyond the current grid
            keep_valid = '0;
        end
    endtask

    // Offer one command beat and wait for its acceptance
    task automatic send_command(input logic cmd, input logic [11:0] px,
                                input logic [11:0] py, input logic [15:0] pr);
        int gap;
        gap = tx_no_idle ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {pr, py, px};
        do @(posedge aclk); while (s_tready !== 1'b1);
        track_best_per_cell(cmd, px, py, pr);
        if (cmd == CMD_FLUSH) flushes_sent++;
        else keypoints_sent++;
    endtask

    // Drop the input, drain the results, then let the cell walk finish
    task automatic settle_block();
        s_tvalid <= 1'b0;
        while (pending_winners.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input cfg_reg_t r, input logic [11:0] v);
        cfg_we    <= 1'b1;
        cfg_addr  <= r;
        cfg_wdata <= v;
        @(posedge aclk);
        case (r)
            REG_CELL_WIDTH:  cell_w_q    = v;
            REG_CELL_HEIGHT: cell_h_q    = v;
            REG_GRID_COLS:   grid_cols_q = v[3:0];
            REG_GRID_ROWS:   grid_rows_q = v[3:0];
            default: ;
        endcase
    endtask

    // Reprogram all four registers while the block is idle
    task automatic configure_grid(input logic [11:0] cw, input logic [11:0] ch,
                                  input logic [11:0] cols_word, input logic [11:0] rows_word);
        settle_block();
        write_reg(REG_CELL_WIDTH, cw);
        write_reg(REG_CELL_HEIGHT, ch);
        write_reg(REG_GRID_COLS, cols_word);
        write_reg(REG_GRID_ROWS, rows_word);
        cfg_we <= 1'b0;
        grid_settings++;
    endtask

    function automatic logic [11:0] pick_cell_size();
        case ($urandom_range(0, 9))
            0: return 12'd0;
            1: return 12'd4095;
            2: return 12'd1;
            default: return 12'($urandom_range(16, 700));
        endcase
    endfunction

    // Grid dimension word with junk in the unused upper bits
    function automatic logic [11:0] pick_grid_word();
        logic [3:0] d;
        case ($urandom_range(0, 9))
            0: d = 4'd0;
            1: d = 4'($urandom_range(9, 15));
            default: d = 4'($urandom_range(1, 8));
        endcase
        return {8'($urandom), d};
    endfunction

    // Compare one accepted result beat with the oldest prediction
    task automatic check_winner();
        cell_winner_t got, want;
        got.idx        = m_tdata[5:0];
        got.wx         = m_tdata[17:6];
        got.wy         = m_tdata[29:18];
        got.wresp      = m_tdata[45:30];
        got.empty_flag = m_tuser;
        got.last_flag  = m_tlast;
        if (pending_winners.size() == 0) begin
            report_mismatch($sformatf("unexpected beat, cell_index %0d", got.idx));
        end else begin
            want = pending_winners.pop_front();
            if (got.idx !== want.idx)
                report_mismatch($sformatf("beat %0d cell_index %0d, want %0d",
                                          winners_seen, got.idx, want.idx));
            if (got.wx !== want.wx)
                report_mismatch($sformatf("beat %0d win_x %0d, want %0d",
                                          winners_seen, got.wx, want.wx));
            if (got.wy !== want.wy)
                report_mismatch($sformatf("beat %0d win_y %0d, want %0d",
                                          winners_seen, got.wy, want.wy));
            if (got.wresp !== want.wresp)
                report_mismatch($sformatf("beat %0d win_response %0d, want %0d",
                                          winners_seen, got.wresp, want.wresp));
            if (got.empty_flag !== want.empty_flag)
                report_mismatch($sformatf("beat %0d empty %b, want %b",
                                          winners_seen, got.empty_flag, want.empty_flag));
            if (got.last_flag !== want.last_flag)
                report_mismatch($sformatf("beat %0d last %b, want %b",
                                          winners_seen, got.last_flag, want.last_flag));
        end
        winners_seen++;
    endtask

    // Result receiver: stall at random, honor a requested long hold-off
    initial begin
        int stall;
        wait (aresetn === 1'b1);
        forever begin
            if (rx_hold_len > 0) begin
                stall = rx_hold_len;
                rx_hold_len = 0;
            end else begin
                stall = rx_no_idle ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
            check_winner();
        end
    end

    // Reset grid: empty flush, ties, corner pixels clamped into the last cells
    task automatic test_reset_grid();
        send_command(CMD_FLUSH, 12'd0, 12'd0, 16'd0);
        send_command(CMD_KEYPOINT, 12'd0, 12'd0, 16'd0);
        send_command(CMD_KEYPOINT, 12'd5, 12'd7, 16'd0);
        send_command(CMD_KEYPOINT, 12'd63, 12'd63, 16'd100);
        send_command(CMD_KEYPOINT, 12'd4095, 12'd4095, 16'hFFFF);
        send_command(CMD_KEYPOINT, 12'd4095, 12'd0, 16'd1);
        send_command(CMD_KEYPOINT, 12'd0, 12'd4095, 16'd2);
        send_command(CMD_KEYPOINT, 12'd511, 12'd511, 16'hFFFE);
        send_command(CMD_KEYPOINT, 12'hAAA, 12'h555, 16'hA5A5);
        send_command(CMD_FLUSH, 12'hFFF, 12'hFFF, 16'hFFFF);
        send_command(CMD_FLUSH, 12'd0, 12'd0, 16'd0);
    endtask

    // Zero cell width, full-size cell height, grid words outside 1..8
    task automatic test_odd_grid();
        configure_grid(12'd0, 12'd4095, 12'hFF0, 12'h00F);
        send_command(CMD_KEYPOINT, 12'd100, 12'd4094, 16'd10);
        send_command(CMD_KEYPOINT, 12'd200, 12'd4095, 16'd20);
        send_command(CMD_FLUSH, 12'd0, 12'd0, 16'd0);
    endtask

    // Entries kept across a grid change: only cells below the new count come out
    task automatic test_grid_change();
        configure_grid(12'd1, 12'd1, 12'd3, 12'd5);
        send_command(CMD_KEYPOINT, 12'd0, 12'd0, 16'd1);
        send_command(CMD_KEYPOINT, 12'd1, 12'd1, 16'd50);
        send_command(CMD_KEYPOINT, 12'd2, 12'd4, 16'd7);
        send_command(CMD_KEYPOINT, 12'd3000, 12'd0, 16'd9);
        configure_grid(12'd4095, 12'd4095, 12'd1, 12'd1);
        send_command(CMD_FLUSH, 12'd0, 12'd0, 16'd0);
        configure_grid(12'd1, 12'd1, 12'd3, 12'd5);
        send_command(CMD_FLUSH, 12'd0, 12'd0, 16'd0);
    endtask

    // Fill all 64 cells, then hold the receiver off while commands keep coming
    task automatic test_output_stall();
        int c;
        configure_grid(12'd64, 12'd64, 12'd8, 12'd8);
        tx_no_idle = 1'b1;
        for (c = 0; c < CELLS; c++) begin
            send_command(CMD_KEYPOINT, 12'((c % 8) * 64 + $urandom_range(0, 63)),
                         12'((c / 8) * 64 + $urandom_range(0, 63)), 16'($urandom));
        end
        rx_hold_len = 600;
        send_command(CMD_FLUSH, 12'($urandom), 12'($urandom), 16'($urandom));
        for (c = 0; c < 20; c++) begin
            send_command(CMD_KEYPOINT, 12'($urandom), 12'($urandom), 16'($urandom));
        end
        send_command(CMD_FLUSH, 12'($urandom), 12'($urandom), 16'($urandom));
        tx_no_idle = 1'b0;
    endtask

    // Random frames of keypoints closed by a flush, with stray flushes and open frames
    task automatic test_random_frames();
        int sent, nkp, k, span_x, span_y;
        logic [11:0] px, py;
        logic [15:0] pr;
        bit tie_mode;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            if (sent == 0 || $urandom_range(0, 2) == 0) begin
                configure_grid(pick_cell_size(), pick_cell_size(),
                               pick_grid_word(), pick_grid_word());
            end
            tx_no_idle = ($urandom_range(0, 3) == 0);
            rx_no_idle = ($urandom_range(0, 3) == 0);
            tie_mode   = ($urandom_range(0, 3) == 0);
            nkp = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60) : $urandom_range(0, 16);
            // aim most keypoints inside the programmed grid
            span_x = int'(cell_w_q) * int'(grid_cols_q);
            span_y = int'(cell_h_q) * int'(grid_rows_q);
            if (span_x == 0 || span_x > 4096) span_x = 4096;
            if (span_y == 0 || span_y > 4096) span_y = 4096;
            for (k = 0; k < nkp; k++) begin
                if ($urandom_range(0, 24) == 0) begin
                    send_command(CMD_FLUSH, 12'($urandom), 12'($urandom), 16'($urandom));
                end else begin
                    if ($urandom_range(0, 4) == 0) begin
                        px = 12'($urandom);
                        py = 12'($urandom);
                    end else begin
                        px = 12'($urandom_range(0, span_x - 1));
                        py = 12'($urandom_range(0, span_y - 1));
                    end
                    pr = tie_mode ? 16'($urandom_range(0, 3)) : 16'($urandom);
                    send_command(CMD_KEYPOINT, px, py, pr);
                end
            end
            sent += nkp;
            if ($urandom_range(0, 6) != 0) begin
                send_command(CMD_FLUSH, 12'($urandom), 12'($urandom), 16'($urandom));
                sent++;
            end
        end
        tx_no_idle = 1'b0;
        rx_no_idle = 1'b0;
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_grid();
        test_odd_grid();
        test_grid_change();
        test_output_stall();
        test_random_frames();
        settle_block();
        $display("Covered %0d keypoints and %0d flushes over %0d grid settings",
                 keypoints_sent, flushes_sent, grid_settings + 1);
        $display("Checked %0d winner beats, %0d mismatches", winners_seen, mismatch_count);
        if (mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/gbk_pkg.sv
rtl/gbk_div_unit.sv
rtl/gbk_cell_store.sv
rtl/grid_bucket_best_keypoint_core.sv
bench/tb_grid_bucket_best_keypoint_core.sv
